// ----- design/i2cmw_pkg.sv -----
// Shared constants and types for the I2C master write serializer.
package i2cmw_pkg;

  localparam int BUS_COUNT     = 3;
  localparam int ENABLE_BITS   = 3;
  localparam int BUS_SLOTS     = 4;
  localparam int BUS_W         = 2;
  localparam int BITS_PER_BYTE = 8;
  localparam int DELAY_W       = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int STEP_W        = 4;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = 1;
  localparam int FIFO_CNT_W    = 2;

  localparam logic [ENABLE_BITS-1:0] BUS_ENABLE_RST  = 3'd7;
  localparam logic [DELAY_W-1:0]     PHASE_DELAY_RST = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY = 1'b1;

  localparam logic [STEP_W-1:0] START_LAST = 4'd2;
  localparam logic [STEP_W-1:0] BYTE_LAST  = STEP_W'(2 * BITS_PER_BYTE - 1);
  localparam logic [STEP_W-1:0] ACK_LAST   = 4'd2;
  localparam logic [STEP_W-1:0] STOP_LAST  = 4'd1;

  typedef struct packed {
    logic [BUS_W-1:0]         bus;
    logic [BITS_PER_BYTE-1:0] data;
    logic                     begin_req;
    logic                     finish;
  } cmd_t;

endpackage

// ----- design/i2cmw_front.sv -----
// Front end: accepts transactions, drops those for missing or disabled buses, queues the rest.
module i2cmw_front (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2cmw_pkg::BUS_W-1:0]         in_bus_id,
  input  logic [i2cmw_pkg::BITS_PER_BYTE-1:0] in_data_byte,
  input  logic                                in_begin_req,
  input  logic                                in_finish,
  input  logic [i2cmw_pkg::ENABLE_BITS-1:0]   bus_enable,
  input  logic                                fifo_full,
  output logic                                fifo_push,
  output i2cmw_pkg::cmd_t                     fifo_cmd
);
  import i2cmw_pkg::*;

  logic [BUS_SLOTS-1:0] en_vec;
  logic                 in_range;
  logic                 keep;

  always_comb begin
    en_vec    = BUS_SLOTS'(bus_enable);
    in_range  = ({1'b0, in_bus_id} < 3'(BUS_COUNT)) && ({1'b0, in_bus_id} < 3'(ENABLE_BITS));
    keep      = in_range && en_vec[in_bus_id];
    in_stall  = fifo_full;
    fifo_push = in_valid && !fifo_full && keep;
    fifo_cmd.bus       = in_bus_id;
    fifo_cmd.data      = in_data_byte;
    fifo_cmd.begin_req = in_begin_req;
    fifo_cmd.finish    = in_finish;
  end

endmodule

// ----- design/i2cmw_fifo.sv -----
// Two-entry queue of byte commands between the front and back ends.
module i2cmw_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cmw_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output i2cmw_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import i2cmw_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
    empty   = (count_r == '0);
    pop_cmd = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/i2cmw_back.sv -----
// Back end: expands one queued byte into timed SDA/SCL pin phases.
module i2cmw_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [i2cmw_pkg::DELAY_W-1:0]   phase_delay,
  input  logic                            fifo_empty,
  input  i2cmw_pkg::cmd_t                 fifo_cmd,
  output logic                            fifo_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [i2cmw_pkg::BUS_W-1:0]     out_bus,
  output logic                            out_sda,
  output logic                            out_scl,
  output logic                            out_last
);
  import i2cmw_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_BYTE  = 5'b00100,
    ST_ACK   = 5'b01000,
    ST_STOP  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [BUS_W-1:0]         bus_r, bus_nxt;
  logic [BITS_PER_BYTE-1:0] shift_r, shift_nxt;
  logic                     finish_r, finish_nxt;
  logic [DELAY_W-1:0]       delay_r, delay_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [BUS_W-1:0]         out_bus_r, out_bus_nxt;
  logic                     out_sda_r, out_sda_nxt;
  logic                     out_scl_r, out_scl_nxt;
  logic                     out_last_r, out_last_nxt;

  logic   slot_free;
  logic   fire;
  logic   ph_sda;
  logic   ph_scl;
  logic   ph_last;
  logic   ph_done;
  state_t ph_next;

  always_comb begin
    ph_sda  = 1'b1;
    ph_scl  = 1'b1;
    ph_last = 1'b0;
    ph_done = 1'b0;
    ph_next = ST_IDLE;
    case (state_r)
      ST_START: begin
        ph_sda  = (step_r == '0);
        ph_scl  = (step_r != START_LAST);
        ph_done = (step_r == START_LAST);
        ph_next = ST_BYTE;
      end
      ST_BYTE: begin
        ph_sda  = shift_r[BITS_PER_BYTE-1];
        ph_scl  = step_r[0];
        ph_done = (step_r == BYTE_LAST);
        ph_next = ST_ACK;
      end
      ST_ACK: begin
        ph_sda  = 1'b1;
        ph_scl  = (step_r == 4'd1);
        ph_done = (step_r == ACK_LAST);
        ph_last = ph_done && !finish_r;
        ph_next = finish_r ? ST_STOP : ST_IDLE;
      end
      ST_STOP: begin
        ph_sda  = (step_r == STOP_LAST);
        ph_scl  = 1'b1;
        ph_done = (step_r == STOP_LAST);
        ph_last = ph_done;
        ph_next = ST_IDLE;
      end
      default: begin
        ph_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    fire      = (state_r != ST_IDLE) && slot_free && (delay_r == '0);
    fifo_pop  = (state_r == ST_IDLE) && !fifo_empty;

    state_nxt  = state_r;
    step_nxt   = step_r;
    bus_nxt    = bus_r;
    shift_nxt  = shift_r;
    finish_nxt = finish_r;

    if (fifo_pop) begin
      bus_nxt    = fifo_cmd.bus;
      shift_nxt  = fifo_cmd.data;
      finish_nxt = fifo_cmd.finish;
      step_nxt   = '0;
      state_nxt  = fifo_cmd.begin_req ? ST_START : ST_BYTE;
    end else if (fire) begin
      if (ph_done) begin
        step_nxt  = '0;
        state_nxt = ph_next;
      end else begin
        step_nxt = step_r + 1'b1;
      end
      if ((state_r == ST_BYTE) && step_r[0]) begin
        shift_nxt = {shift_r[BITS_PER_BYTE-2:0], 1'b0};
      end
    end

    if (fire) begin
      delay_nxt = phase_delay;
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 1'b1;
    end else begin
      delay_nxt = delay_r;
    end

    out_valid_nxt = out_valid_r;
    out_bus_nxt   = out_bus_r;
    out_sda_nxt   = out_sda_r;
    out_scl_nxt   = out_scl_r;
    out_last_nxt  = out_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_bus_nxt   = bus_r;
      out_sda_nxt   = ph_sda;
      out_scl_nxt   = ph_scl;
      out_last_nxt  = ph_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      delay_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      delay_r     <= delay_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bus_r      <= bus_nxt;
    shift_r    <= shift_nxt;
    finish_r   <= finish_nxt;
    out_bus_r  <= out_bus_nxt;
    out_sda_r  <= out_sda_nxt;
    out_scl_r  <= out_scl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_bus   = out_bus_r;
  assign out_sda   = out_sda_r;
  assign out_scl   = out_scl_r;
  assign out_last  = out_last_r;

endmodule

// ----- design/i2c_master_write_serializer.sv -----
// Top level of the write-only I2C master serializer with its configuration registers.
// Each input transaction carries one byte for one bus, with optional start and stop marks.
// The block turns it into a stream of pin phases (bus, SDA, SCL), one output transaction
// per phase: an optional start (3 phases), the byte MSB first (16 phases), three ack clock
// phases with SDA released, and an optional stop (2 phases), 19 to 24 phases in all.
// The last phase of a byte carries out_last. Bytes for a bus that does not exist or whose
// bus_enable bit is clear are accepted and give no output.
// Input and output use valid/stall; a transaction moves when valid is high and stall is low.
// An accepted byte waits in a two-entry queue, so the input keeps accepting while a byte
// is being sent and in_stall rises only when the queue is full.
// An accepted byte is written into the queue, popped into the sequencer registers, and its
// first phase is then registered at the output. The phase sequencer issues one phase, then
// counts down phase_delay before the next one can issue. The fetch of the next byte from
// the queue overlaps that countdown, and is hidden behind it unless phase_delay = 0.
// An output stall holds the current phase; the delay count keeps running meanwhile.
// Reset is synchronous and active low: queue and sequencer empty, bus_enable = 7,
// phase_delay = 10. Configuration is written through cfg_we, cfg_index and cfg_wdata.
module i2c_master_write_serializer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cmw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cmw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2cmw_pkg::BUS_W-1:0]         in_bus_id,
  input  logic [i2cmw_pkg::BITS_PER_BYTE-1:0] in_data_byte,
  input  logic                                in_begin_req,
  input  logic                                in_finish,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [i2cmw_pkg::BUS_W-1:0]         out_bus,
  output logic                                out_sda,
  output logic                                out_scl,
  output logic                                out_last
);
  import i2cmw_pkg::*;

  logic [ENABLE_BITS-1:0] bus_enable_r, bus_enable_nxt;
  logic [DELAY_W-1:0]     phase_delay_r, phase_delay_nxt;

  logic fifo_push;
  logic fifo_pop;
  logic fifo_full;
  logic fifo_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  always_comb begin
    bus_enable_nxt  = bus_enable_r;
    phase_delay_nxt = phase_delay_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BUS_ENABLE:  bus_enable_nxt  = cfg_wdata[ENABLE_BITS-1:0];
        CFG_PHASE_DELAY: phase_delay_nxt = cfg_wdata[DELAY_W-1:0];
        default: begin
          bus_enable_nxt = bus_enable_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_enable_r  <= BUS_ENABLE_RST;
      phase_delay_r <= PHASE_DELAY_RST;
    end else begin
      bus_enable_r  <= bus_enable_nxt;
      phase_delay_r <= phase_delay_nxt;
    end
  end

  i2cmw_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bus_id    (in_bus_id),
    .in_data_byte (in_data_byte),
    .in_begin_req (in_begin_req),
    .in_finish    (in_finish),
    .bus_enable   (bus_enable_r),
    .fifo_full    (fifo_full),
    .fifo_push    (fifo_push),
    .fifo_cmd     (push_cmd)
  );

  i2cmw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  i2cmw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_delay (phase_delay_r),
    .fifo_empty  (fifo_empty),
    .fifo_cmd    (pop_cmd),
    .fifo_pop    (fifo_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_bus     (out_bus),
    .out_sda     (out_sda),
    .out_scl     (out_scl),
    .out_last    (out_last)
  );

`ifndef SYNTHESIS
  a_last_releases_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_sda)
    else $error("final phase of a byte does not release SDA");

  a_bus_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_bus} < 3'(BUS_COUNT)))
    else $error("phase issued for a bus that does not exist");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("queue popped while empty");

  a_dropped_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && ({1'b0, in_bus_id} >= 3'(BUS_COUNT)) |-> !fifo_push)
    else $error("transaction for a missing bus entered the queue");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master write serializer with random stimulus and stalls.
module tb_top;
  import i2cmw_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [BUS_W-1:0] bus;
    logic             sda;
    logic             scl;
    logic             last;
  } pin_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BUS_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BUS_W-1:0] in_bus_id = '0;
  logic [BITS_PER_BYTE-1:0] in_data_byte = '0;
  logic in_begin_req = 1'b0;
  logic in_finish = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BUS_W-1:0] out_bus;
  logic out_sda;
  logic out_scl;
  logic out_last;

  cmd_t bytes_to_send[$];
  pin_phase_t pin_phases_due[$];
  logic [ENABLE_BITS-1:0] bus_enable_copy = BUS_ENABLE_RST;
  logic [DELAY_W-1:0] phase_delay_copy = PHASE_DELAY_RST;
  logic [1:0] line_levels[BUS_SLOTS] = '{default: 2'b11};

  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int send_gap = 0;
  int rx_left = 0;
  int hold_left = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int quiet_cycles = 0;
  int errors = 0;

  i2c_master_write_serializer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_bus_id(in_bus_id), .in_data_byte(in_data_byte),
    .in_begin_req(in_begin_req), .in_finish(in_finish),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bus(out_bus), .out_sda(out_sda), .out_scl(out_scl), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit bus_live(logic [BUS_W-1:0] b);
    return b < BUS_COUNT && b < ENABLE_BITS && bus_enable_copy[b];
  endfunction

  function automatic int push_phase(logic [BUS_W-1:0] b, logic sda, logic scl, int k, int total);
    pin_phase_t p;
    p.bus = b;
    p.sda = sda;
    p.scl = scl;
    p.last = (k == total - 1);
    pin_phases_due.push_back(p);
    line_levels[b] = {sda, scl};
    return k + 1;
  endfunction

  function automatic void expand_byte(cmd_t c);
    int total;
    int k;
    logic [BITS_PER_BYTE-1:0] d;
    if (!bus_live(c.bus)) return;
    total = 2 * BITS_PER_BYTE + 3 + (c.begin_req ? 3 : 0) + (c.finish ? 2 : 0);
    k = 0;
    d = c.data;
    if (c.begin_req) begin
      k = push_phase(c.bus, 1'b1, 1'b1, k, total);
      k = push_phase(c.bus, 1'b0, 1'b1, k, total);
      k = push_phase(c.bus, 1'b0, 1'b0, k, total);
    end
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      k = push_phase(c.bus, d[BITS_PER_BYTE-1], 1'b0, k, total);
      k = push_phase(c.bus, d[BITS_PER_BYTE-1], 1'b1, k, total);
      d = d << 1;
    end
    k = push_phase(c.bus, 1'b1, 1'b0, k, total);
    k = push_phase(c.bus, 1'b1, 1'b1, k, total);
    k = push_phase(c.bus, 1'b1, 1'b0, k, total);
    if (c.finish) begin
      k = push_phase(c.bus, 1'b0, 1'b1, k, total);
      k = push_phase(c.bus, 1'b1, 1'b1, k, total);
    end
  endfunction

  function automatic void check_phase();
    pin_phase_t want;
    if (pin_phases_due.size() == 0) begin
      $display("%0t: unexpected phase bus %0d sda %0d scl %0d last %0d",
               $time, out_bus, out_sda, out_scl, out_last);
      errors++;
      return;
    end
    want = pin_phases_due.pop_front();
    if (out_bus !== want.bus) begin
      $display("%0t: out_bus expected %0d, got %0d", $time, want.bus, out_bus);
      errors++;
    end
    if (out_sda !== want.sda) begin
      $display("%0t: out_sda expected %0d, got %0d", $time, want.sda, out_sda);
      errors++;
    end
    if (out_scl !== want.scl) begin
      $display("%0t: out_scl expected %0d, got %0d", $time, want.scl, out_scl);
      errors++;
    end
    if (out_last !== want.last) begin
      $display("%0t: out_last expected %0d, got %0d", $time, want.last, out_last);
      errors++;
    end
  endfunction

  // Monitor: records both handshakes and checks each accepted phase.
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    out_acc <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall)
      expand_byte({in_bus_id, in_data_byte, in_begin_req, in_finish});
    if (rst_n && out_valid && !out_stall)
      check_phase();
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL i2c_master_write_serializer");
      $finish;
    end
  end

  // Driver: offers queued bytes, with a random gap after each one while tx_idle_on is set.
  always @(negedge clk) begin
    logic v;
    cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (v && in_acc) v = 1'b0;
      if (!v) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (bytes_to_send.size() != 0) begin
          c = bytes_to_send.pop_front();
          in_bus_id <= c.bus;
          in_data_byte <= c.data;
          in_begin_req <= c.begin_req;
          in_finish <= c.finish;
          v = 1'b1;
          send_gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        end
      end
      in_valid <= v;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (out_acc) rx_left = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_left != 0) begin
        rx_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void offer(logic [BUS_W-1:0] b, logic [BITS_PER_BYTE-1:0] d,
                                logic bg, logic fi);
    cmd_t c;
    c.bus = b;
    c.data = d;
    c.begin_req = bg;
    c.finish = fi;
    bytes_to_send.push_back(c);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUS_ENABLE)
      bus_enable_copy = val[ENABLE_BITS-1:0];
    else
      phase_delay_copy = val;
  endtask

  task automatic configure(input logic [ENABLE_BITS-1:0] en, input logic [DELAY_W-1:0] dly);
    logic [CFG_DATA_W-1:0] wd;
    wd = CFG_DATA_W'($urandom_range(0, 255));
    wd[ENABLE_BITS-1:0] = en;
    write_reg(CFG_BUS_ENABLE, wd);
    write_reg(CFG_PHASE_DELAY, dly);
  endtask

  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid || pin_phases_due.size() != 0)
      @(posedge clk);
    repeat (2 * (phase_delay_copy + 1) + 20) @(posedge clk);
  endtask

  initial begin
    int made;
    int n;
    logic [BUS_W-1:0] b;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    offer(2'd0, 8'h00, 1'b1, 1'b1);
    offer(2'd1, 8'hFF, 1'b1, 1'b0);
    offer(2'd1, 8'h80, 1'b0, 1'b0);
    offer(2'd1, 8'h01, 1'b0, 1'b1);
    offer(2'd2, 8'hA5, 1'b0, 1'b1);
    offer(2'd2, 8'h5A, 1'b1, 1'b0);
    offer(2'd3, 8'hFF, 1'b1, 1'b1);
    offer(2'd0, 8'hC3, 1'b0, 1'b0);
    wait_idle();

    configure(3'd0, 8'd0);
    for (int i = 0; i < BUS_SLOTS; i++) offer(BUS_W'(i), 8'hFF, 1'b1, 1'b1);
    wait_idle();

    configure(3'd5, 8'd1);
    offer(2'd0, 8'h0F, 1'b1, 1'b1);
    offer(2'd1, 8'hF0, 1'b1, 1'b1);
    offer(2'd2, 8'h3C, 1'b1, 1'b1);
    offer(2'd3, 8'h00, 1'b0, 1'b0);
    wait_idle();

    configure(3'd2, 8'd255);
    offer(2'd1, 8'h96, 1'b1, 1'b1);
    offer(2'd0, 8'hAA, 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      configure(p < 2 ? 3'd7 : ($urandom_range(0, 1) ? 3'd7 : 3'($urandom_range(1, 6))),
                p == 0 ? 8'd0 : 8'($urandom_range(1, 8)));
      tx_idle_on = (p != 1 && p != 4);
      rx_idle_on = (p != 2 && p != 4);
      if (p == 1) hold_ticket++;
      made = 0;
      while (made < 40) begin
        if ($urandom_range(0, 4) != 0) begin
          b = ($urandom_range(0, 9) == 0) ? 2'd3 : BUS_W'($urandom_range(0, 2));
          n = $urandom_range(1, 4);
          for (int j = 0; j < n; j++) begin
            offer(b, BITS_PER_BYTE'($urandom_range(0, 255)), j == 0, j == n - 1);
            made++;
          end
        end else begin
          b = BUS_W'($urandom_range(0, 3));
          offer(b, BITS_PER_BYTE'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
          made++;
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS i2c_master_write_serializer");
    end else begin
      $display("FAIL i2c_master_write_serializer");
    end
    $finish;
  end

endmodule
